FILE: rtl/sdo_object_dictionary_server_macros.svh
// assertion macros shared by the search unit and the top-level server
`ifndef SDO_OBJECT_DICTIONARY_SERVER_MACROS_SVH
`define SDO_OBJECT_DICTIONARY_SERVER_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, off while reset is asserted
`define SDO_OD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sdo_od assertion failed");
// clocked property, checked on every edge
`define SDO_OD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sdo_od assertion failed");
`else
`define SDO_OD_ASSERT(lbl, clk, rst_n, prop)
`define SDO_OD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/sdo_od_pkg.sv
`timescale 1ns / 1ps

package sdo_od_pkg;

    // request beat
    typedef struct packed {
        logic [7:0]  cmd;
        logic [15:0] object_index;
        logic [7:0]  object_subindex;
        logic [31:0] request_data;
    } t_req;

    // response beat
    typedef struct packed {
        logic [7:0]  resp_cmd;
        logic [15:0] resp_index;
        logic [7:0]  resp_subindex;
        logic [31:0] resp_data;
        logic [2:0]  status;
        logic        is_payload;
        logic        last;
    } t_resp;

    // search result handed from the search unit to the sequencer
    typedef struct packed {
        logic       done;
        logic       found;
        logic [7:0] slot;
        logic [1:0] acc;
        logic [4:0] len;
    } t_hit;

    // command bytes
    localparam logic [7:0] CMD_UPLOAD_REQ = 8'h40;
    localparam logic [7:0] CMD_UP_EXP     = 8'h43;
    localparam logic [7:0] CMD_UP_NORMAL  = 8'h41;
    localparam logic [7:0] CMD_DN_ACK     = 8'h60;
    localparam logic [7:0] CMD_ABORT      = 8'h80;
    localparam logic [2:0] CMD_DN_CLASS   = 3'b001;

    // access codes
    localparam logic [1:0] ACC_EMPTY = 2'd0;
    localparam logic [1:0] ACC_RO    = 2'd1;
    localparam logic [1:0] ACC_WO    = 2'd2;
    localparam logic [1:0] ACC_RW    = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_OBJ   = 3'd1;
    localparam logic [2:0] ST_WO       = 3'd2;
    localparam logic [2:0] ST_RO       = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;
    localparam logic [2:0] ST_UNSUPP   = 3'd5;
    localparam logic [2:0] ST_BAD_CMD  = 3'd6;
    localparam logic [2:0] ST_INTERNAL = 3'd7;

    // abort codes
    localparam logic [31:0] ABORT_BAD_CMD  = 32'h0504_0001;
    localparam logic [31:0] ABORT_NO_OBJ   = 32'h0602_0000;
    localparam logic [31:0] ABORT_WO       = 32'h0601_0001;
    localparam logic [31:0] ABORT_RO       = 32'h0601_0002;
    localparam logic [31:0] ABORT_UNSUPP   = 32'h0601_0000;
    localparam logic [31:0] ABORT_LENGTH   = 32'h0607_0010;
    localparam logic [31:0] ABORT_INTERNAL = 32'h0800_0000;

    // descriptor layout: length, access, subindex, index
    function automatic logic [30:0] mk_desc(input logic [15:0] ix, input logic [7:0] sb,
                                            input logic [1:0] ac, input logic [4:0] ln);
        return {ln, ac, sb, ix};
    endfunction

    // built-in dictionary descriptors, empty beyond the image
    function automatic logic [30:0] img_desc(input logic [7:0] slot);
        logic [30:0] d;
        unique case (slot)
            8'd0:    d = mk_desc(16'h1000, 8'd0, ACC_RO, 5'd4);
            8'd1:    d = mk_desc(16'h1008, 8'd0, ACC_RO, 5'd12);
            8'd2:    d = mk_desc(16'h1009, 8'd0, ACC_RO, 5'd3);
            8'd3:    d = mk_desc(16'h100A, 8'd0, ACC_RO, 5'd5);
            8'd4:    d = mk_desc(16'h1018, 8'd0, ACC_RO, 5'd1);
            8'd5:    d = mk_desc(16'h1018, 8'd1, ACC_RO, 5'd4);
            8'd6:    d = mk_desc(16'h1018, 8'd2, ACC_RO, 5'd4);
            8'd7:    d = mk_desc(16'h1018, 8'd3, ACC_RO, 5'd4);
            8'd8:    d = mk_desc(16'h1018, 8'd4, ACC_RO, 5'd4);
            8'd9:    d = mk_desc(16'h2000, 8'd0, ACC_RW, 5'd4);
            8'd10:   d = mk_desc(16'h2001, 8'd0, ACC_RO, 5'd4);
            default: d = '0;
        endcase
        return d;
    endfunction

    // built-in payload words, zero everywhere else
    function automatic logic [31:0] img_word(input logic [7:0] slot, input logic [4:0] w);
        logic [31:0] v;
        v = '0;
        unique case (slot)
            8'd1: begin
                unique case (w)
                    5'd0:    v = 32'h3835_5841;
                    5'd1:    v = 32'h5F30_3031;
                    5'd2:    v = 32'h7473_6554;
                    default: v = '0;
                endcase
            end
            8'd2:  v = (w == 5'd0) ? 32'h0030_2E31 : 32'h0;
            8'd3: begin
                unique case (w)
                    5'd0:    v = 32'h2E30_2E31;
                    5'd1:    v = 32'h0000_0030;
                    default: v = '0;
                endcase
            end
            8'd4:  v = (w == 5'd0) ? 32'h0000_0004 : 32'h0;
            8'd5:  v = (w == 5'd0) ? 32'h0000_0596 : 32'h0;
            8'd6:  v = (w == 5'd0) ? 32'h5810_0000 : 32'h0;
            8'd7:  v = (w == 5'd0) ? 32'h0001_0000 : 32'h0;
            8'd8:  v = (w == 5'd0) ? 32'h0000_0001 : 32'h0;
            8'd10: v = (w == 5'd0) ? 32'h1234_5678 : 32'h0;
            default: v = '0;
        endcase
        return v;
    endfunction

    // mask of the low n bytes, all ones from four up
    function automatic logic [31:0] byte_mask(input logic [4:0] n);
        logic [31:0] m;
        unique case (n)
            5'd0:    m = 32'h0000_0000;
            5'd1:    m = 32'h0000_00FF;
            5'd2:    m = 32'h0000_FFFF;
            5'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // pack one response beat
    function automatic t_resp mk_resp(input logic [7:0] c, input logic [15:0] ix,
                                      input logic [7:0] sb, input logic [31:0] d,
                                      input logic [2:0] st, input logic pay,
                                      input logic lst);
        t_resp r;
        r.resp_cmd      = c;
        r.resp_index    = ix;
        r.resp_subindex = sb;
        r.resp_data     = d;
        r.status        = st;
        r.is_payload    = pay;
        r.last          = lst;
        return r;
    endfunction

endpackage

FILE: rtl/sdo_od_search.sv
`timescale 1ns / 1ps
`include "sdo_object_dictionary_server_macros.svh"

module sdo_od_search
    import sdo_od_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [15:0] i_index,
    input  logic [7:0]  i_subindex,
    output t_hit        o_hit
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(ENTRIES - 1);

    logic          r_busy;
    logic [SW-1:0] r_slot;
    logic [15:0]   r_index;
    logic [7:0]    r_subindex;
    t_hit          r_hit;
    logic [30:0]   w_desc;
    logic          w_match;

    // one descriptor compared per cycle
    always_comb begin
        w_desc  = img_desc(8'(r_slot));
        w_match = (w_desc[25:24] != ACC_EMPTY) && (w_desc[15:0] == r_index)
                  && (w_desc[23:16] == r_subindex);
    end

    // slot walker, lowest matching slot wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_hit  <= '0;
        end else begin
            r_hit.done <= 1'b0;
            if (i_go) begin
                r_busy     <= 1'b1;
                r_slot     <= '0;
                r_index    <= i_index;
                r_subindex <= i_subindex;
            end else if (r_busy) begin
                if (w_match || (r_slot == LAST_SLOT)) begin
                    r_busy      <= 1'b0;
                    r_hit.done  <= 1'b1;
                    r_hit.found <= w_match;
                    r_hit.slot  <= 8'(r_slot);
                    r_hit.acc   <= w_desc[25:24];
                    r_hit.len   <= w_desc[30:26];
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    assign o_hit = r_hit;

    // the walk ends only with a result
    `SDO_OD_ASSERT(a_end_has_done, i_clk, i_rst_n, r_busy && !i_go |=> r_busy || r_hit.done)
    // the last slot always closes the walk
    `SDO_OD_ASSERT(a_last_slot_ends, i_clk, i_rst_n, r_busy && !i_go && r_slot == LAST_SLOT |=> !r_busy)
    // a result is never raised while still walking
    `SDO_OD_ASSERT(a_done_idle, i_clk, i_rst_n, r_hit.done |-> !r_busy || $past(i_go))

endmodule

FILE: rtl/sdo_od_store.sv
`timescale 1ns / 1ps

module sdo_od_store
    import sdo_od_pkg::*;
#(
    parameter int ENTRIES         = 16,
    parameter int WORDS_PER_ENTRY = 4,
    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int WW = (WORDS_PER_ENTRY > 1) ? $clog2(WORDS_PER_ENTRY) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [SW-1:0]         i_rd_slot,
    input  logic [WW-1:0]         i_rd_word,
    output logic [31:0]           o_rd_data,
    input  logic                  i_wr_en,
    input  logic [SW-1:0]         i_wr_slot,
    input  logic [31:0]           i_wr_data
);

    // only word 0 of an object is ever written; the rest stays the image
    logic [31:0]        r_word0 [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [31:0]        r_rd_mem;
    logic [31:0]        r_rd_img;
    logic               r_rd_sel;

    // written word-0 memory with registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_word0[i_wr_slot] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_mem <= r_word0[i_rd_slot];
            r_rd_img <= img_word(8'(i_rd_slot), 5'(i_rd_word));
            r_rd_sel <= (i_rd_word == '0) && r_valid[i_rd_slot];
        end
    end

    // one valid bit per object, an unwritten word reads as the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_slot] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_sel ? r_rd_mem : r_rd_img;

endmodule

FILE: rtl/sdo_object_dictionary_server.sv
`timescale 1ns / 1ps
`include "sdo_object_dictionary_server_macros.svh"
// channel    | ports                      | handshake
// -----------+----------------------------+------------------------------------
// request    | start, busy, i_req         | beat taken when start && !busy
// response   | o_resp_strobe, o_resp      | beat valid for one cycle on strobe
//
// The descriptor search compares one slot per cycle and stops at the matching
// slot (ENTRIES-1 on a miss). An abort or normal upload header is registered in
// S_SEARCH; an expedited upload passes S_UP_EXP, a download acknowledge S_DN_WR.
// Payload words follow the header one per cycle; busy drops with the last beat.
// Reset is synchronous; written object data falls back to the built-in image.
// The response side cannot stall; every beat must be taken on its strobe.

module sdo_object_dictionary_server
    import sdo_od_pkg::*;
#(
    parameter int ENTRIES           = 16,
    parameter int MAX_PAYLOAD_BYTES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_req  i_req,
    output logic  busy,
    output logic  o_resp_strobe,
    output t_resp o_resp
);

    localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WPE = (MAX_PAYLOAD_BYTES + 3) / 4;
    localparam int WW  = (WPE > 1) ? $clog2(WPE) : 1;
    localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD_BYTES);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SEARCH  = 5'b00010,
        S_UP_EXP  = 5'b00100,
        S_UP_WORD = 5'b01000,
        S_DN_WR   = 5'b10000
    } t_state;

    t_state        r_state;
    t_req          r_req;
    t_resp         r_resp;
    logic          r_strobe;
    logic [SW-1:0] r_slot;
    logic [4:0]    r_len;
    logic [4:0]    r_remain;
    logic [WW-1:0] r_word;
    logic [2:0]    r_dn_n;

    t_hit          w_hit;
    logic          w_go;
    logic          w_bad_cmd;
    logic          w_upload;
    logic [2:0]    w_dn_n;
    logic          w_rd_en;
    logic [SW-1:0] w_rd_slot;
    logic [WW-1:0] w_rd_word;
    logic [31:0]   w_rd_data;
    logic          w_wr_en;
    logic [31:0]   w_wr_data;
    logic [31:0]   w_dn_mask;
    logic [7:0]    w_exp_cmd;
    logic          w_word_last;

    assign busy = (r_state != S_IDLE);
    assign w_go = start && !busy;

    sdo_od_search #(
        .ENTRIES (ENTRIES)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_index    (i_req.object_index),
        .i_subindex (i_req.object_subindex),
        .o_hit      (w_hit)
    );

    sdo_od_store #(
        .ENTRIES         (ENTRIES),
        .WORDS_PER_ENTRY (WPE)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_slot (w_rd_slot),
        .i_rd_word (w_rd_word),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_slot (r_slot),
        .i_wr_data (w_wr_data)
    );

    // command decode
    always_comb begin
        w_upload  = (r_req.cmd == CMD_UPLOAD_REQ);
        w_bad_cmd = !w_upload && (r_req.cmd[7:5] != CMD_DN_CLASS);
        w_dn_n    = 3'd4 - {1'b0, r_req.cmd[3:2]};
    end

    // store read requests
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_slot = SW'(w_hit.slot);
        w_rd_word = '0;
        unique case (r_state)
            S_SEARCH: w_rd_en = w_hit.done;
            S_UP_WORD: begin
                w_rd_en   = 1'b1;
                w_rd_slot = r_slot;
                w_rd_word = r_word;
            end
            default: w_rd_en = 1'b0;
        endcase
    end

    // download merge of the low bytes into word 0
    always_comb begin
        w_dn_mask = byte_mask({2'b00, r_dn_n});
        w_wr_en   = (r_state == S_DN_WR);
        w_wr_data = (w_rd_data & ~w_dn_mask) | (r_req.request_data & w_dn_mask);
    end

    // reply codes
    always_comb begin
        w_exp_cmd   = CMD_UP_EXP | {4'b0000, 2'(3'd4 - r_len[2:0]), 2'b00};
        w_word_last = (r_remain <= 5'd4);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_hit.done) begin
                        r_slot   <= SW'(w_hit.slot);
                        r_len    <= w_hit.len;
                        r_remain <= w_hit.len;
                        r_word   <= WW'(1);
                        r_dn_n   <= w_dn_n;
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                        priority if (w_bad_cmd) begin
                            r_resp <= mk_resp(CMD_ABORT, r_req.object_index,
                                r_req.object_subindex, ABORT_BAD_CMD, ST_BAD_CMD, 1'b0, 1'b1);
                        end else if (!w_hit.found) begin
                            r_resp <= mk_resp(CMD_ABORT, r_req.object_index,
                                r_req.object_subindex, ABORT_NO_OBJ, ST_NO_OBJ, 1'b0, 1'b1);
                        end else if (w_upload && (w_hit.acc == ACC_WO)) begin
                            r_resp <= mk_resp(CMD_ABORT, r_req.object_index,
                                r_req.object_subindex, ABORT_WO, ST_WO, 1'b0, 1'b1);
                        end else if (w_upload && (w_hit.len <= 5'd4)) begin
                            r_strobe <= 1'b0;
                            r_state  <= S_UP_EXP;
                        end else if (w_upload && ({2'b00, w_hit.len} > MAX_LEN)) begin
                            r_resp <= mk_resp(CMD_ABORT, r_req.object_index,
                                r_req.object_subindex, ABORT_INTERNAL, ST_INTERNAL,
                                1'b0, 1'b1);
                        end else if (w_upload) begin
                            // normal upload header carries the length
                            r_resp  <= mk_resp(CMD_UP_NORMAL, r_req.object_index,
                                r_req.object_subindex, {27'd0, w_hit.len}, ST_OK, 1'b0, 1'b0);
                            r_state <= S_UP_WORD;
                        end else if (w_hit.acc == ACC_RO) begin
                            r_resp <= mk_resp(CMD_ABORT, r_req.object_index,
                                r_req.object_subindex, ABORT_RO, ST_RO, 1'b0, 1'b1);
                        end else if (!r_req.cmd[1]) begin
                            r_resp <= mk_resp(CMD_ABORT, r_req.object_index,
                                r_req.object_subindex, ABORT_UNSUPP, ST_UNSUPP, 1'b0, 1'b1);
                        end else if ({2'b00, w_dn_n} > w_hit.len) begin
                            r_resp <= mk_resp(CMD_ABORT, r_req.object_index,
                                r_req.object_subindex, ABORT_LENGTH, ST_LENGTH, 1'b0, 1'b1);
                        end else begin
                            r_strobe <= 1'b0;
                            r_state  <= S_DN_WR;
                        end
                    end
                end
                S_UP_EXP: begin
                    r_resp   <= mk_resp(w_exp_cmd, r_req.object_index, r_req.object_subindex,
                        w_rd_data & byte_mask(r_len), ST_OK, 1'b0, 1'b1);
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_UP_WORD: begin
                    r_resp   <= mk_resp(CMD_UP_NORMAL, r_req.object_index,
                        r_req.object_subindex, w_rd_data & byte_mask(r_remain), ST_OK,
                        1'b1, w_word_last);
                    r_strobe <= 1'b1;
                    if (w_word_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_remain <= r_remain - 5'd4;
                        r_word   <= r_word + 1'b1;
                    end
                end
                S_DN_WR: begin
                    r_resp   <= mk_resp(CMD_DN_ACK, r_req.object_index, r_req.object_subindex,
                        32'd0, ST_OK, 1'b0, 1'b1);
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_resp_strobe = r_strobe;
    assign o_resp        = r_resp;

    // a taken request keeps the block busy
    `SDO_OD_ASSERT(a_start_busy, i_clk, i_rst_n, start && !busy |=> busy)
    // the final beat frees the request side
    `SDO_OD_ASSERT(a_last_frees, i_clk, i_rst_n, o_resp_strobe && o_resp.last |-> !busy)
    // a beat that is not final comes while still busy
    `SDO_OD_ASSERT(a_more_busy, i_clk, i_rst_n, o_resp_strobe && !o_resp.last |-> busy)
    // search results are only seen by the waiting sequencer
    `SDO_OD_ASSERT_ALWAYS(a_hit_in_search, i_clk, !i_rst_n || !w_hit.done || r_state == S_SEARCH)

endmodule
